/* hdl/cubic_curve_point_evaluator_defines.svh */
// assertion macros for the cubic curve evaluator
`ifndef CUBIC_CURVE_POINT_EVALUATOR_DEFINES_SVH
`define CUBIC_CURVE_POINT_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define CCPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ccpe_pkg.sv */
package ccpe_pkg;

  typedef enum logic [1:0] {
    FUNC_BEZIER  = 2'd0,
    FUNC_BSPLINE = 2'd1,
    FUNC_CATMULL = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DIV_ONE = 2'd0,
    DIV_TWO = 2'd1,
    DIV_SIX = 2'd2
  } div_e;

  typedef struct packed {
    logic zero;
    div_e div;
  } ctl_t;

  // divide by three, one digit per stage
  localparam int DIGIT_W = 16;
  localparam int RECIP_SHIFT = DIGIT_W + 3;
  localparam logic [DIGIT_W+1:0] RECIP3 = (DIGIT_W + 2)'((1 << RECIP_SHIFT) / 3 + 1);

endpackage

/* hdl/ccpe_coef.sv */
module ccpe_coef #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_W       = 39
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_0_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_1_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_2_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_3_i,
  input  logic [FRAC_BITS:0]            param_t_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ACC_W-1:0]       acc_o,
  output logic [3*ACC_W-1:0]            coef_o,
  output logic [FRAC_BITS:0]            t_o,
  output ccpe_pkg::ctl_t                ctl_o
);
  import ccpe_pkg::*;

  localparam int EXT_W = ACC_W - VALUE_WIDTH;
  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [ACC_W-1:0] x3(input logic signed [ACC_W-1:0] x);
    return (x <<< 1) + x;
  endfunction

  logic signed [ACC_W-1:0] p0, p1, p2, p3;
  logic signed [ACC_W-1:0] a_d, b_d, c_d, d_d;
  logic [FRAC_BITS:0]      t_d;
  ctl_t                    ctl_d;

  logic                    vld_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [3*ACC_W-1:0]      coef_q;
  logic [FRAC_BITS:0]      t_q;
  ctl_t                    ctl_q;

  always_comb begin
    p0 = {{EXT_W{ctrl_0_i[VALUE_WIDTH-1]}}, ctrl_0_i};
    p1 = {{EXT_W{ctrl_1_i[VALUE_WIDTH-1]}}, ctrl_1_i};
    p2 = {{EXT_W{ctrl_2_i[VALUE_WIDTH-1]}}, ctrl_2_i};
    p3 = {{EXT_W{ctrl_3_i[VALUE_WIDTH-1]}}, ctrl_3_i};
    a_d = p3 - p0 + x3(p1) - x3(p2);
    ctl_d.zero = 1'b0;
    case (func_i)
      FUNC_BEZIER: begin
        b_d = x3(p0) - (x3(p1) <<< 1) + x3(p2);
        c_d = x3(p1) - x3(p0);
        d_d = p0;
        ctl_d.div = DIV_ONE;
      end
      FUNC_BSPLINE: begin
        b_d = x3(p0) - (x3(p1) <<< 1) + x3(p2);
        c_d = x3(p2) - x3(p0);
        d_d = p0 + (p1 <<< 2) + p2;
        ctl_d.div = DIV_SIX;
      end
      FUNC_CATMULL: begin
        b_d = (p0 <<< 1) - x3(p1) - (p1 <<< 1) + (p2 <<< 2) - p3;
        c_d = p2 - p0;
        d_d = p1 <<< 1;
        ctl_d.div = DIV_TWO;
      end
      default: begin
        b_d = '0;
        c_d = '0;
        d_d = '0;
        ctl_d.zero = 1'b1;
        ctl_d.div = DIV_ONE;
      end
    endcase
    t_d = (param_t_i > T_ONE) ? T_ONE : param_t_i;
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      acc_q  <= a_d;
      coef_q <= {d_d, c_d, b_d};
      t_q    <= t_d;
      ctl_q  <= ctl_d;
    end
  end

  assign out_valid_o = vld_q;
  assign acc_o       = acc_q;
  assign coef_o      = coef_q;
  assign t_o         = t_q;
  assign ctl_o       = ctl_q;

endmodule

/* hdl/ccpe_step.sv */
module ccpe_step #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 39
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic [3*ACC_W-1:0]      coef_i,
  input  logic [FRAC_BITS:0]      t_i,
  input  ccpe_pkg::ctl_t          ctl_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic [3*ACC_W-1:0]      coef_o,
  output logic [FRAC_BITS:0]      t_o,
  output ccpe_pkg::ctl_t          ctl_o
);
  import ccpe_pkg::*;

  localparam int TW    = FRAC_BITS + 1;
  localparam int LO_W  = ACC_W / 2;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int PL_W  = LO_W + TW;
  localparam int PH_W  = HI_W + TW + 1;
  localparam int SUM_W = ACC_W + TW + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic [LO_W-1:0]        lo;
  logic signed [HI_W-1:0] hi;
  logic signed [TW:0]     t_s;
  logic [PL_W-1:0]        plo_d;
  logic signed [PH_W-1:0] phi_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rnd;
  logic signed [ACC_W-1:0] acc_d;
  logic                    rdy1;

  // partial products
  logic                   vld0_q;
  logic [PL_W-1:0]        plo_q;
  logic signed [PH_W-1:0] phi_q;
  logic [3*ACC_W-1:0]     coef0_q;
  logic [FRAC_BITS:0]     t0_q;
  ctl_t                   ctl0_q;

  // rounded product plus coefficient
  logic                    vld1_q;
  logic signed [ACC_W-1:0] acc1_q;
  logic [3*ACC_W-1:0]      coef1_q;
  logic [FRAC_BITS:0]      t1_q;
  ctl_t                    ctl1_q;

  always_comb begin
    lo    = acc_i[LO_W-1:0];
    hi    = acc_i[ACC_W-1:LO_W];
    t_s   = {1'b0, t_i};
    plo_d = PL_W'(lo) * PL_W'(t_i);
    phi_d = PH_W'(hi) * PH_W'(t_s);
  end

  always_comb begin
    sum   = (SUM_W'(phi_q) <<< LO_W) + $signed(SUM_W'(plo_q)) + $signed(HALF);
    rnd   = sum >>> FRAC_BITS;
    acc_d = $signed(rnd[ACC_W-1:0]) + $signed(coef0_q[ACC_W-1:0]);
  end

  assign rdy1       = !vld1_q || out_ready_i;
  assign in_ready_o = !vld0_q || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        vld0_q <= in_valid_i;
      end
      if (rdy1) begin
        vld1_q <= vld0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      coef0_q <= coef_i;
      t0_q    <= t_i;
      ctl0_q  <= ctl_i;
    end
    if (rdy1) begin
      acc1_q  <= acc_d;
      coef1_q <= {{ACC_W{1'b0}}, coef0_q[3*ACC_W-1:ACC_W]};
      t1_q    <= t0_q;
      ctl1_q  <= ctl0_q;
    end
  end

  assign out_valid_o = vld1_q;
  assign acc_o       = acc1_q;
  assign coef_o      = coef1_q;
  assign t_o         = t1_q;
  assign ctl_o       = ctl1_q;

endmodule

/* hdl/ccpe_div.sv */
module ccpe_div #(
  parameter int ACC_W = 39
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ACC_W-1:0] acc_i,
  input  ccpe_pkg::ctl_t          ctl_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ACC_W-1:0] value_o,
  output ccpe_pkg::ctl_t          ctl_o
);
  import ccpe_pkg::*;

  localparam int YW  = ACC_W + 1;
  localparam int ND  = (YW + DIGIT_W - 1) / DIGIT_W;
  localparam int PW  = ND * DIGIT_W;
  localparam int VDW = DIGIT_W + 2;
  localparam logic [YW-1:0]    Y_BIAS = YW'(3) << (ACC_W - 1);
  localparam logic [ACC_W-1:0] Q_BIAS = {1'b1, {(ACC_W - 1){1'b0}}};

  logic signed [ACC_W:0]   acc_x;
  logic signed [ACC_W:0]   acc_r;
  logic signed [ACC_W-1:0] u_d;
  logic [YW-1:0]           y;
  logic [VDW-1:0]          v      [ND:1];
  logic [2*VDW-1:0]        prod   [ND:1];
  logic [DIGIT_W-1:0]      qd     [ND:1];
  logic [VDW-1:0]          r_full [ND:1];
  logic [PW-1:0]           num_d  [ND:0];
  logic [1:0]              rem_d  [ND:0];
  logic [ND+1:0]           rdy;
  logic [ACC_W-1:0]        quot;

  logic [ND:0]             vld_q;
  logic [PW-1:0]           num_q [ND:0];
  logic [1:0]              rem_q [ND:0];
  logic signed [ACC_W-1:0] u_q   [ND:0];
  ctl_t                    ctl_q [ND:0];

  // pre-rounding by half the divisor, then bias to a non-negative numerator
  always_comb begin
    acc_x = {acc_i[ACC_W-1], acc_i};
    case (ctl_i.div)
      DIV_TWO: acc_r = (acc_x + $signed((ACC_W + 1)'(1))) >>> 1;
      DIV_SIX: acc_r = (acc_x + $signed((ACC_W + 1)'(3))) >>> 1;
      default: acc_r = acc_x;
    endcase
    u_d = acc_r[ACC_W-1:0];
    y   = {u_d[ACC_W-1], u_d} + Y_BIAS;
  end

  // long division by three, top digit first, quotient shifts in at the bottom
  always_comb begin
    num_d[0] = PW'(y);
    rem_d[0] = 2'd0;
    for (int k = 1; k <= ND; k++) begin
      v[k]      = {rem_q[k-1], num_q[k-1][PW-1 -: DIGIT_W]};
      prod[k]   = (2 * VDW)'(v[k]) * (2 * VDW)'(RECIP3);
      qd[k]     = prod[k][RECIP_SHIFT +: DIGIT_W];
      r_full[k] = v[k] - VDW'({qd[k], 1'b0}) - VDW'(qd[k]);
      rem_d[k]  = r_full[k][1:0];
      num_d[k]  = {num_q[k-1][PW-DIGIT_W-1:0], qd[k]};
    end
  end

  always_comb begin
    rdy[ND+1] = out_ready_i;
    for (int s = ND; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= ND; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      num_q[0] <= num_d[0];
      rem_q[0] <= rem_d[0];
      u_q[0]   <= u_d;
      ctl_q[0] <= ctl_i;
    end
    for (int s = 1; s <= ND; s++) begin
      if (rdy[s]) begin
        num_q[s] <= num_d[s];
        rem_q[s] <= rem_d[s];
        u_q[s]   <= u_q[s-1];
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign quot        = num_q[ND][ACC_W-1:0];
  assign value_o     = (ctl_q[ND].div == DIV_SIX) ? $signed(quot - Q_BIAS) : u_q[ND];
  assign ctl_o       = ctl_q[ND];
  assign out_valid_o = vld_q[ND];

endmodule

/* hdl/cubic_curve_point_evaluator.sv */
// channel | handshake             | payload
// --------+-----------------------+-----------------------------------------------
// request | in_valid_i/in_ready_o | func_i, ctrl_0_i..ctrl_3_i, param_t_i
// result  | out_valid_o/out_ready_i | curve_value_o, saturated_o
//
// one request per cycle while the result side keeps up; the stages, in order:
// coefficient stage, three Horner steps of two stages each (split multiply, round and add),
// one pre-round stage, one divide-by-three stage per 16-bit digit, one saturation stage.
// rst_ni clears all stage valid bits; payload registers are not reset.
// every stage holds while the one after it is full and stalled, so bubbles close up
// and in_ready_o falls only when the whole pipe is full and the result is not taken.
`include "cubic_curve_point_evaluator_defines.svh"

module cubic_curve_point_evaluator #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_0_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_1_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_2_i,
  input  logic signed [VALUE_WIDTH-1:0] ctrl_3_i,
  input  logic [FRAC_BITS:0]            param_t_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] curve_value_o,
  output logic                          saturated_o
);
  import ccpe_pkg::*;

  localparam int ACC_W = VALUE_WIDTH + 7;
  localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  logic                    cf_valid, cf_ready;
  logic signed [ACC_W-1:0] cf_acc;
  logic [3*ACC_W-1:0]      cf_coef;
  logic [FRAC_BITS:0]      cf_t;
  ctl_t                    cf_ctl;

  logic                    s1_valid, s1_ready;
  logic signed [ACC_W-1:0] s1_acc;
  logic [3*ACC_W-1:0]      s1_coef;
  logic [FRAC_BITS:0]      s1_t;
  ctl_t                    s1_ctl;

  logic                    s2_valid, s2_ready;
  logic signed [ACC_W-1:0] s2_acc;
  logic [3*ACC_W-1:0]      s2_coef;
  logic [FRAC_BITS:0]      s2_t;
  ctl_t                    s2_ctl;

  logic                    s3_valid, s3_ready;
  logic signed [ACC_W-1:0] s3_acc;
  ctl_t                    s3_ctl;

  logic                    dv_valid, dv_ready;
  logic signed [ACC_W-1:0] dv_value;
  ctl_t                    dv_ctl;

  logic                    over, under;
  logic [VALUE_WIDTH-1:0]  res_d;
  logic                    sat_d;
  logic                    out_vld_q;
  logic [VALUE_WIDTH-1:0]  res_q;
  logic                    sat_q;

  ccpe_coef #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .ACC_W       (ACC_W)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .ctrl_0_i    (ctrl_0_i),
    .ctrl_1_i    (ctrl_1_i),
    .ctrl_2_i    (ctrl_2_i),
    .ctrl_3_i    (ctrl_3_i),
    .param_t_i   (param_t_i),
    .out_valid_o (cf_valid),
    .out_ready_i (cf_ready),
    .acc_o       (cf_acc),
    .coef_o      (cf_coef),
    .t_o         (cf_t),
    .ctl_o       (cf_ctl)
  );

  ccpe_step #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_step_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cf_valid),
    .in_ready_o  (cf_ready),
    .acc_i       (cf_acc),
    .coef_i      (cf_coef),
    .t_i         (cf_t),
    .ctl_i       (cf_ctl),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .acc_o       (s1_acc),
    .coef_o      (s1_coef),
    .t_o         (s1_t),
    .ctl_o       (s1_ctl)
  );

  ccpe_step #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_step_c (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .acc_i       (s1_acc),
    .coef_i      (s1_coef),
    .t_i         (s1_t),
    .ctl_i       (s1_ctl),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .acc_o       (s2_acc),
    .coef_o      (s2_coef),
    .t_o         (s2_t),
    .ctl_o       (s2_ctl)
  );

  ccpe_step #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_step_d (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .acc_i       (s2_acc),
    .coef_i      (s2_coef),
    .t_i         (s2_t),
    .ctl_i       (s2_ctl),
    .out_valid_o (s3_valid),
    .out_ready_i (s3_ready),
    .acc_o       (s3_acc),
    .coef_o      (),
    .t_o         (),
    .ctl_o       (s3_ctl)
  );

  ccpe_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid),
    .in_ready_o  (s3_ready),
    .acc_i       (s3_acc),
    .ctl_i       (s3_ctl),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .value_o     (dv_value),
    .ctl_o       (dv_ctl)
  );

  // saturation to the output range; an unused selector gives zero
  always_comb begin
    over  = !dv_value[ACC_W-1] && (|dv_value[ACC_W-2:VALUE_WIDTH-1]);
    under = dv_value[ACC_W-1] && !(&dv_value[ACC_W-2:VALUE_WIDTH-1]);
    if (dv_ctl.zero) begin
      res_d = '0;
      sat_d = 1'b0;
    end else if (over) begin
      res_d = V_MAX;
      sat_d = 1'b1;
    end else if (under) begin
      res_d = V_MIN;
      sat_d = 1'b1;
    end else begin
      res_d = dv_value[VALUE_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  assign dv_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (dv_ready) begin
      out_vld_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign curve_value_o = res_q;
  assign saturated_o   = sat_q;

  `CCPE_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, cf_valid, "accepted request lost at the coefficient stage")
  `CCPE_ASSERT_IMP(a_full_only_when_stalled, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while the result side moves")
  `CCPE_ASSERT_IMP(a_sat_at_limit, out_valid_o && saturated_o, (curve_value_o == $signed(V_MAX)) || (curve_value_o == $signed(V_MIN)), "saturated result not at a range limit")

endmodule

/* verif/cubic_curve_point_evaluator_checker.sv */
module cubic_curve_point_evaluator_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] ctrl_0_i,
  input  logic signed [31:0] ctrl_1_i,
  input  logic signed [31:0] ctrl_2_i,
  input  logic signed [31:0] ctrl_3_i,
  input  logic [16:0]        param_t_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] curve_value_i,
  input  logic               saturated_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccpe_pkg::*;

  localparam int     FRAC_BITS = 16;
  localparam longint T_ONE     = 64'sd65536;
  localparam longint HALF_T    = 64'sd32768;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } curve_point_t;

  curve_point_t expected_points[$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    checked_o     = 0;
    clipped_o     = 0;
  end

  // rounded product of accumulator and t, ties toward plus infinity
  function automatic longint round_scale(longint x, longint t);
    return (x * t + HALF_T) >>> FRAC_BITS;
  endfunction

  function automatic curve_point_t eval_curve(logic [1:0] basis, logic signed [31:0] c0,
                                              logic signed [31:0] c1, logic signed [31:0] c2,
                                              logic signed [31:0] c3, logic [16:0] t_raw);
    longint       p0, p1, p2, p3, a, b, c, d, den, t, acc, num, q;
    curve_point_t r;
    p0 = c0;
    p1 = c1;
    p2 = c2;
    p3 = c3;
    t  = (t_raw > 17'd65536) ? T_ONE : longint'(t_raw);
    r.value = '0;
    r.sat   = 1'b0;
    a = -p0 + 3 * p1 - 3 * p2 + p3;
    case (basis)
      FUNC_BEZIER: begin
        b = 3 * p0 - 6 * p1 + 3 * p2;
        c = -3 * p0 + 3 * p1;
        d = p0;
        den = 1;
      end
      FUNC_BSPLINE: begin
        b = 3 * p0 - 6 * p1 + 3 * p2;
        c = -3 * p0 + 3 * p2;
        d = p0 + 4 * p1 + p2;
        den = 6;
      end
      FUNC_CATMULL: begin
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = -p0 + p2;
        d = 2 * p1;
        den = 2;
      end
      default: return r;
    endcase
    acc = round_scale(a, t) + b;
    acc = round_scale(acc, t) + c;
    acc = round_scale(acc, t) + d;
    num = acc + den / 2;
    q   = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    if (q > VALUE_MAX) begin
      q = VALUE_MAX;
      r.sat = 1'b1;
    end else if (q < VALUE_MIN) begin
      q = VALUE_MIN;
      r.sat = 1'b1;
    end
    r.value = q[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    error_count_o++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : watch
    curve_point_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_points.push_back(eval_curve(func_i, ctrl_0_i, ctrl_1_i, ctrl_2_i, ctrl_3_i,
                                             param_t_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          error_count_o++;
          $display("%0t: result with no request pending, expected none, actual %0d / %0b",
                   $time, curve_value_i, saturated_i);
        end else begin
          want = expected_points.pop_front();
          if (curve_value_i !== want.value) begin
            report_mismatch("curve_value", want.value, curve_value_i);
          end
          if (saturated_i !== want.sat) begin
            report_mismatch("saturated", want.sat, saturated_i);
          end
          checked_o++;
          if (want.sat) clipped_o++;
        end
      end
    end
    pending_o = expected_points.size();
  end

endmodule

/* verif/cubic_curve_point_evaluator_test.sv */
module cubic_curve_point_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccpe_pkg::*;

  localparam logic [1:0]         FUNC_UNUSED  = 2'd3;
  localparam logic signed [31:0] VAL_MAX      = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q        = 32'sd65536;
  localparam logic [16:0]        T_ONE        = 17'd65536;
  localparam logic [16:0]        T_TOP        = 17'h1ffff;
  localparam int                 RANDOM_ITEMS = 1700;
  localparam int                 CALM_ITEMS   = 200;
  localparam int                 CYCLE_LIMIT  = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         func_i;
  logic signed [31:0] ctrl_0_i;
  logic signed [31:0] ctrl_1_i;
  logic signed [31:0] ctrl_2_i;
  logic signed [31:0] ctrl_3_i;
  logic [16:0]        param_t_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] curve_value_o;
  logic               saturated_o;

  int error_count;
  int pending_count;
  int checked_count;
  int clipped_count;
  int basis_count[4];
  int cycle_count;
  int send_idle_pct;
  bit calm_tail;

  cubic_curve_point_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .ctrl_0_i      (ctrl_0_i),
    .ctrl_1_i      (ctrl_1_i),
    .ctrl_2_i      (ctrl_2_i),
    .ctrl_3_i      (ctrl_3_i),
    .param_t_i     (param_t_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_value_o (curve_value_o),
    .saturated_o   (saturated_o)
  );

  cubic_curve_point_evaluator_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .ctrl_0_i      (ctrl_0_i),
    .ctrl_1_i      (ctrl_1_i),
    .ctrl_2_i      (ctrl_2_i),
    .ctrl_3_i      (ctrl_3_i),
    .param_t_i     (param_t_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_value_i (curve_value_o),
    .saturated_i   (saturated_o),
    .error_count_o (error_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count),
    .clipped_o     (clipped_count)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_ctrl();
    int v;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        v = $urandom_range(0, 2097152);
        return v - 1048576;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 17'($urandom_range(0, 65536));
      6, 7: return 17'($urandom_range(0, 131071));
      8: begin
        case ($urandom_range(0, 3))
          0: return 17'd0;
          1: return 17'd1;
          2: return 17'd65535;
          default: return T_ONE;
        endcase
      end
      default: return 17'($urandom_range(65537, 131071));
    endcase
  endfunction

  task automatic send_request(input logic [1:0] basis, input logic signed [31:0] c0,
                              input logic signed [31:0] c1, input logic signed [31:0] c2,
                              input logic signed [31:0] c3, input logic [16:0] t);
    if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= basis;
    ctrl_0_i   <= c0;
    ctrl_1_i   <= c1;
    ctrl_2_i   <= c2;
    ctrl_3_i   <= c3;
    param_t_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    basis_count[basis]++;
  endtask

  // result side back-pressure
  initial begin
    int stall_pct;
    int steps;
    out_ready_i = 1'b0;
    stall_pct   = 0;
    steps       = 0;
    wait (rst_ni);
    forever begin
      if (steps % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      steps++;
      if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    logic [1:0]         basis;
    logic signed [31:0] c0, c1, c2, c3, hi, lo, swap;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_BEZIER;
    ctrl_0_i      = '0;
    ctrl_1_i      = '0;
    ctrl_2_i      = '0;
    ctrl_3_i      = '0;
    param_t_i     = '0;
    calm_tail     = 1'b0;
    send_idle_pct = 0;
    basis_count   = '{default: 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(FUNC_BEZIER, 0, 0, 0, 0, 17'd0);
    send_request(FUNC_BEZIER, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 17'd32768);
    send_request(FUNC_BEZIER, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, T_ONE);
    send_request(FUNC_BEZIER, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, T_TOP);
    send_request(FUNC_BEZIER, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 17'd21845);
    send_request(FUNC_BEZIER, -1, -1, -1, -1, 17'd65535);
    send_request(FUNC_BSPLINE, 0, 0, 0, 0, 17'd0);
    send_request(FUNC_BSPLINE, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 17'd32768);
    send_request(FUNC_BSPLINE, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, T_ONE);
    send_request(FUNC_BSPLINE, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 17'd100000);
    send_request(FUNC_BSPLINE, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                 32'shaaaa_aaaa, 17'h0aaaa);
    send_request(FUNC_BSPLINE, ONE_Q, -ONE_Q, 3, -7, 17'd1);
    send_request(FUNC_CATMULL, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 17'd0);
    // overshoot past either end of the range
    send_request(FUNC_CATMULL, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 17'd32768);
    send_request(FUNC_CATMULL, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, 17'd32768);
    send_request(FUNC_CATMULL, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 17'd65535);
    send_request(FUNC_CATMULL, ONE_Q, 5 * ONE_Q, -3 * ONE_Q, 7, T_TOP);
    send_request(FUNC_CATMULL, 1, -1, 1, -1, 17'd32768);
    send_request(FUNC_UNUSED, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, T_ONE);
    send_request(FUNC_UNUSED, 0, 0, 0, 0, 17'd0);
    send_request(FUNC_UNUSED, VAL_MIN, VAL_MAX, -1, 1, T_TOP);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 50;
        endcase
      end
      calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
      basis = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) begin
        hi = VAL_MAX - 32'($urandom_range(0, 65535));
        lo = VAL_MIN + 32'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) begin
          swap = hi;
          hi   = lo;
          lo   = swap;
        end
        c0 = lo;
        c1 = hi;
        c2 = hi;
        c3 = lo;
      end else begin
        c0 = rand_ctrl();
        c1 = rand_ctrl();
        c2 = rand_ctrl();
        c3 = rand_ctrl();
      end
      send_request(basis, c0, c1, c2, c3, rand_t());
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (20) @(posedge clk_i);

    $display("%0d requests: %0d bezier, %0d b-spline, %0d catmull-rom, %0d unused selector",
             basis_count[0] + basis_count[1] + basis_count[2] + basis_count[3],
             basis_count[0], basis_count[1], basis_count[2], basis_count[3]);
    $display("%0d results checked, %0d clipped to range", checked_count, clipped_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
